### design/stl_pkg.sv
// Shared types, constants and helper functions of the script text lexer.
// No dependencies; used by every module of the lexer.
package stl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int NEST_BITS     = 8;
  localparam int POS_OUT_W     = 16;
  localparam int KIND_W        = 6;
  localparam int MAX_RES       = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [NEST_BITS-1:0]     nest_t;
  typedef logic [KIND_W-1:0]        kind_t;

  // lexer modes
  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_CR        = 4'd1;
  localparam logic [3:0] M_OP        = 4'd2;
  localparam logic [3:0] M_DOT1      = 4'd3;
  localparam logic [3:0] M_DOT2      = 4'd4;
  localparam logic [3:0] M_NUM       = 4'd5;
  localparam logic [3:0] M_ID        = 4'd6;
  localparam logic [3:0] M_STR       = 4'd7;
  localparam logic [3:0] M_QUOTE     = 4'd8;
  localparam logic [3:0] M_CMT       = 4'd9;
  localparam logic [3:0] M_CMT_SLASH = 4'd10;
  localparam logic [3:0] M_CMT_STAR  = 4'd11;
  localparam logic [3:0] M_CMT_CR    = 4'd12;

  // token kinds
  localparam kind_t K_CHRSEQ = 6'd0;
  localparam kind_t K_ID     = 6'd1;
  localparam kind_t K_NUM    = 6'd2;
  localparam kind_t K_STR_DQ = 6'd3;
  localparam kind_t K_STR_SQ = 6'd4;
  localparam kind_t K_BTICK  = 6'd5;
  localparam kind_t K_CMT    = 6'd6;
  localparam kind_t K_NL     = 6'd7;
  localparam kind_t K_SEMI   = 6'd8;
  localparam kind_t K_COMMA  = 6'd9;
  localparam kind_t K_HASH   = 6'd10;
  localparam kind_t K_LBRK   = 6'd11;
  localparam kind_t K_RBRK   = 6'd12;
  localparam kind_t K_LBRC   = 6'd13;
  localparam kind_t K_RBRC   = 6'd14;
  localparam kind_t K_LPAR   = 6'd15;
  localparam kind_t K_RPAR   = 6'd16;
  localparam kind_t K_DOT    = 6'd58;
  localparam kind_t K_DOT2   = 6'd59;
  localparam kind_t K_DOT3   = 6'd60;
  localparam kind_t K_ARROW  = 6'd61;
  localparam kind_t K_EOF    = 6'd62;
  localparam kind_t K_NONE   = 6'd63;

  // special characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic             is_text;
    logic [7:0]       text_byte;
    kind_t            kind;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] column;
  } res_t;

  // all results caused by one input item
  typedef struct packed {
    logic [2:0]            cnt;
    res_t [MAX_RES-1:0]    res;
  } bundle_t;

  typedef struct packed {
    kind_t k1;
    kind_t ks;
    kind_t ke;
  } opk_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == {POSITION_BITS{1'b1}}) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [POS_OUT_W-1:0] clamp_pos(pos_t v);
    logic [POSITION_BITS+POS_OUT_W-1:0] w;
    w = {{POS_OUT_W{1'b0}}, v};
    if (w > {{POSITION_BITS{1'b0}}, {POS_OUT_W{1'b1}}}) return {POS_OUT_W{1'b1}};
    return w[POS_OUT_W-1:0];
  endfunction

  function automatic res_t mk_text(logic [7:0] b);
    res_t r;
    r = '0;
    r.is_text   = 1'b1;
    r.text_byte = b;
    return r;
  endfunction

  function automatic res_t mk_close(kind_t k, pos_t ln, pos_t cl);
    res_t r;
    r = '0;
    r.kind   = k;
    r.line   = clamp_pos(ln);
    r.column = clamp_pos(cl);
    return r;
  endfunction

  function automatic bundle_t put(bundle_t b, res_t r);
    bundle_t o;
    o = b;
    if (b.cnt < 3'(MAX_RES)) begin
      o.res[b.cnt[1:0]] = r;
      o.cnt = b.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic opk_t op_kinds(logic [7:0] h);
    opk_t o;
    o = '{k1: K_CHRSEQ, ks: K_NONE, ke: K_NONE};
    unique case (h)
      8'h3D: o = '{k1: 6'd17, ks: K_NONE, ke: 6'd18};  // =
      8'h3F: o = '{k1: 6'd19, ks: K_NONE, ke: 6'd20};  // ?
      8'h21: o = '{k1: 6'd23, ks: K_NONE, ke: 6'd24};  // !
      8'h7E: o = '{k1: 6'd25, ks: K_NONE, ke: 6'd26};  // ~
      8'h2A: o = '{k1: 6'd27, ks: K_NONE, ke: 6'd28};  // *
      8'h40: o = '{k1: 6'd29, ks: 6'd30,  ke: K_NONE}; // @
      8'h3C: o = '{k1: 6'd31, ks: 6'd32,  ke: 6'd33};  // <
      8'h3E: o = '{k1: 6'd34, ks: 6'd35,  ke: 6'd36};  // >
      8'h7C: o = '{k1: 6'd37, ks: 6'd38,  ke: 6'd39};  // |
      8'h26: o = '{k1: 6'd40, ks: 6'd41,  ke: 6'd42};  // &
      8'h2B: o = '{k1: 6'd43, ks: 6'd44,  ke: 6'd45};  // +
      8'h25: o = '{k1: 6'd49, ks: 6'd50,  ke: 6'd51};  // %
      8'h5E: o = '{k1: 6'd52, ks: 6'd53,  ke: 6'd54};  // ^
      8'h3A: o = '{k1: 6'd55, ks: 6'd56,  ke: 6'd57};  // :
      8'h2D: o = '{k1: 6'd46, ks: 6'd47,  ke: 6'd48};  // -
      8'h2F: o = '{k1: 6'd21, ks: K_NONE, ke: 6'd22};  // /
      default: o = '{k1: K_CHRSEQ, ks: K_NONE, ke: K_NONE};
    endcase
    return o;
  endfunction

  // single-character punctuation tokens
  function automatic kind_t punct_kind(logic [7:0] c);
    kind_t k;
    unique case (c)
      8'h3B:   k = K_SEMI;
      8'h2C:   k = K_COMMA;
      8'h23:   k = K_HASH;
      8'h5B:   k = K_LBRK;
      8'h5D:   k = K_RBRK;
      8'h7B:   k = K_LBRC;
      8'h7D:   k = K_RBRC;
      8'h28:   k = K_LPAR;
      8'h29:   k = K_RPAR;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'h5F;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

endpackage

### design/stl_front.sv
// Lexer front end: mode state machine that classifies each byte and
// builds the bundle of results it causes. Depends on stl_pkg.
module stl_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic            func,
  input  logic [7:0]      char_byte,
  output stl_pkg::bundle_t bundle
);
  import stl_pkg::*;

  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  closer_r, closer_nxt;
  nest_t       nest_r, nest_nxt;
  pos_t        line_r, line_nxt;
  pos_t        col_r, col_nxt;
  kind_t       okind_r, okind_nxt;
  pos_t        oline_r, oline_nxt;
  pos_t        ocol_r, ocol_nxt;

  // next state and results of one item
  always_comb begin
    logic [7:0] c;
    logic       done;
    pos_t       bf;
    opk_t       ok;
    kind_t      k;
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    closer_nxt = closer_r;
    nest_nxt   = nest_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    okind_nxt  = okind_r;
    oline_nxt  = oline_r;
    ocol_nxt   = ocol_r;
    bundle     = '0;
    c          = char_byte;
    done       = 1'b0;
    bf         = col_r;
    ok         = op_kinds(held_r);
    k          = K_NONE;
    if (func) begin
      // end of input: close any open token, then end-of-file
      unique case (mode_r)
        M_OP:    bundle = put(bundle, mk_close(ok.k1, line_r, col_r));
        M_DOT1:  bundle = put(bundle, mk_close(K_DOT, line_r, col_r));
        M_DOT2:  bundle = put(bundle, mk_close(K_DOT2, line_r, col_r));
        M_QUOTE: bundle = put(bundle, mk_close(K_BTICK, line_r, col_r));
        M_NUM, M_ID, M_STR, M_CMT, M_CMT_SLASH, M_CMT_STAR, M_CMT_CR:
          bundle = put(bundle, mk_close(okind_r, oline_r, ocol_r));
        default: ;
      endcase
      bundle   = put(bundle, mk_close(K_EOF, line_r, col_r));
      mode_nxt = M_IDLE;
      nest_nxt = '0;
    end else if ((mode_r == M_CR || mode_r == M_CMT_CR) && c == CH_LF) begin
      // LF after CR is part of the same newline
      mode_nxt = (mode_r == M_CR) ? M_IDLE : M_CMT;
    end else begin
      bf      = col_r;
      col_nxt = sat_inc(col_r);
      // a rejected lookahead byte is reprocessed, at most three passes
      for (int p = 0; p < 3; p++) begin
        if (!done) begin
          unique case (mode_nxt)
            M_OP: begin
              ok = op_kinds(held_nxt);
              k  = K_NONE;
              if (c == CH_EQ && ok.ke != K_NONE) k = ok.ke;
              else if (c == held_nxt && ok.ks != K_NONE) k = ok.ks;
              else if (held_nxt == CH_MINUS && c == CH_GT) k = K_ARROW;
              if (k != K_NONE) begin
                bundle   = put(bundle, mk_close(k, line_nxt, col_nxt));
                mode_nxt = M_IDLE;
                done     = 1'b1;
              end else if (held_nxt == CH_MINUS && is_digit(c)) begin
                okind_nxt = K_NUM; oline_nxt = line_nxt; ocol_nxt = bf;
                mode_nxt  = M_NUM;
                bundle    = put(bundle, mk_text(CH_MINUS));
                bundle    = put(bundle, mk_text(c));
                done      = 1'b1;
              end else if (held_nxt == CH_SLASH && c == CH_STAR) begin
                okind_nxt = K_CMT; oline_nxt = line_nxt; ocol_nxt = col_nxt;
                mode_nxt  = M_CMT;
                nest_nxt  = nest_t'(1);
                done      = 1'b1;
              end else begin
                bundle   = put(bundle, mk_close(ok.k1, line_nxt, bf));
                mode_nxt = M_IDLE;
              end
            end
            M_DOT1: begin
              if (c == CH_DOT) begin
                mode_nxt = M_DOT2;
                done     = 1'b1;
              end else if (is_digit(c)) begin
                okind_nxt = K_NUM; oline_nxt = line_nxt; ocol_nxt = bf;
                mode_nxt  = M_NUM;
                bundle    = put(bundle, mk_text(CH_DOT));
                bundle    = put(bundle, mk_text(c));
                done      = 1'b1;
              end else begin
                bundle   = put(bundle, mk_close(K_DOT, line_nxt, bf));
                mode_nxt = M_IDLE;
              end
            end
            M_DOT2: begin
              mode_nxt = M_IDLE;
              if (c == CH_DOT) begin
                bundle = put(bundle, mk_close(K_DOT3, line_nxt, col_nxt));
                done   = 1'b1;
              end else begin
                bundle = put(bundle, mk_close(K_DOT2, line_nxt, bf));
              end
            end
            M_NUM, M_ID: begin
              if ((mode_nxt == M_NUM) ? (is_ident(c) || c == CH_DOT) : is_ident(c)) begin
                bundle = put(bundle, mk_text(c));
                done   = 1'b1;
              end else begin
                bundle   = put(bundle, mk_close(okind_nxt, oline_nxt, ocol_nxt));
                mode_nxt = M_IDLE;
              end
            end
            M_STR: begin
              if (c == closer_nxt) begin
                bundle   = put(bundle, mk_close(okind_nxt, oline_nxt, ocol_nxt));
                mode_nxt = M_IDLE;
              end else begin
                bundle = put(bundle, mk_text(c));
              end
              done = 1'b1;
            end
            M_QUOTE: begin
              if (c != CH_CR && c != CH_LF) begin
                bundle = put(bundle, mk_text(c));
                done   = 1'b1;
              end else begin
                bundle   = put(bundle, mk_close(K_BTICK, line_nxt, bf));
                mode_nxt = M_IDLE;
              end
            end
            M_CMT_SLASH: begin
              mode_nxt = M_CMT;
              if (c == CH_STAR) begin
                if (nest_nxt != {NEST_BITS{1'b1}}) nest_nxt = nest_nxt + nest_t'(1);
                done = 1'b1;
              end
            end
            M_CMT_STAR: begin
              mode_nxt = M_CMT;
              if (c == CH_SLASH) begin
                if (nest_nxt != '0) nest_nxt = nest_nxt - nest_t'(1);
                if (nest_nxt == '0) begin
                  bundle   = put(bundle, mk_close(okind_nxt, oline_nxt, ocol_nxt));
                  mode_nxt = M_IDLE;
                end
                done = 1'b1;
              end
            end
            M_CMT, M_CMT_CR: begin
              mode_nxt = M_CMT;
              if (c == CH_SLASH) mode_nxt = M_CMT_SLASH;
              else if (c == CH_STAR) mode_nxt = M_CMT_STAR;
              else if (c == CH_CR || c == CH_LF) begin
                line_nxt = sat_inc(line_nxt);
                col_nxt  = '0;
                if (c == CH_CR) mode_nxt = M_CMT_CR;
              end
              done = 1'b1;
            end
            default: begin
              // start of a new token
              ok       = op_kinds(c);
              k        = punct_kind(c);
              mode_nxt = M_IDLE;
              done     = 1'b1;
              priority if (c == CH_CR || c == CH_LF) begin
                bundle   = put(bundle, mk_close(K_NL, line_nxt, col_nxt));
                line_nxt = sat_inc(line_nxt);
                col_nxt  = '0;
                if (c == CH_CR) mode_nxt = M_CR;
              end else if (k != K_NONE) begin
                bundle = put(bundle, mk_close(k, line_nxt, col_nxt));
              end else if (c == CH_DOT) begin
                mode_nxt = M_DOT1;
              end else if (c == CH_BTICK) begin
                mode_nxt = M_QUOTE;
              end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                closer_nxt = c;
                okind_nxt  = (c == CH_DQUOTE) ? K_STR_DQ : K_STR_SQ;
                oline_nxt  = line_nxt; ocol_nxt = col_nxt;
                mode_nxt   = M_STR;
              end else if (c == CH_DOLLAR) begin
                okind_nxt = K_NUM; oline_nxt = line_nxt; ocol_nxt = col_nxt;
                mode_nxt  = M_NUM;
                bundle    = put(bundle, mk_text(CH_ZERO));
                bundle    = put(bundle, mk_text(CH_X));
              end else if (ok.ke != K_NONE || ok.ks != K_NONE) begin
                held_nxt = c;
                mode_nxt = M_OP;
              end else if (is_blank(c)) begin
                mode_nxt = M_IDLE;
              end else if (is_digit(c)) begin
                okind_nxt = K_NUM; oline_nxt = line_nxt; ocol_nxt = col_nxt;
                mode_nxt  = M_NUM;
                bundle    = put(bundle, mk_text(c));
              end else if (is_ident(c)) begin
                okind_nxt = K_ID; oline_nxt = line_nxt; ocol_nxt = col_nxt;
                mode_nxt  = M_ID;
                bundle    = put(bundle, mk_text(c));
              end else begin
                bundle = put(bundle, mk_text(c));
                bundle = put(bundle, mk_close(K_CHRSEQ, line_nxt, col_nxt));
              end
            end
          endcase
        end
      end
    end
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      held_r   <= '0;
      closer_r <= '0;
      nest_r   <= '0;
      line_r   <= '0;
      col_r    <= '0;
      okind_r  <= '0;
      oline_r  <= '0;
      ocol_r   <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      closer_r <= closer_nxt;
      nest_r   <= nest_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      okind_r  <= okind_nxt;
      oline_r  <= oline_nxt;
      ocol_r   <= ocol_nxt;
    end
  end

endmodule

### design/stl_queue.sv
// Short queue of result bundles between lexer front and back end.
// Depends on stl_pkg.
module stl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  stl_pkg::bundle_t wr_data,
  input  logic             rd,
  output stl_pkg::bundle_t rd_data,
  output logic             full,
  output logic             empty
);
  import stl_pkg::*;

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_wr, do_rd;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_rd) rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_r + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end
  end

endmodule

### design/stl_back.sv
// Lexer back end: hands out the results of the head bundle one per transfer.
// Depends on stl_pkg and reads the bundle queue head.
module stl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stl_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             head_pop,
  input  logic             pop,
  output logic             empty,
  output stl_pkg::res_t    res,
  output logic             last
);
  import stl_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       xfer;

  assign empty    = !head_valid;
  assign res      = head.res[idx_r];
  assign last     = ({1'b0, idx_r} + 3'd1) == head.cnt;
  assign xfer     = pop && head_valid;
  assign head_pop = xfer && last;

  // result index within the head bundle
  always_comb begin
    idx_nxt = idx_r;
    if (xfer) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head.cnt)) else $error("index past bundle end");
  a_no_empty_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (head.cnt != 3'd0)) else $error("empty bundle queued");
  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> (idx_r == 2'd0)) else $error("index not cleared after bundle");

endmodule

### design/script_text_lexer_unit.sv
// Script text lexer top level: front end, bundle queue, back end.
// Latency: a result can be popped the cycle after its byte's transfer.
// Throughput: one byte per cycle while results are popped as fast; a byte
// causes up to 4 results, which are handed out one per pop.
// The 4-entry bundle queue sets how far input may run ahead of output.
// Reset (rst_n low, synchronous) empties the queue and idles the lexer.
module script_text_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_char_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_is_text,
  output logic [7:0]  out_text_byte,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_line,
  output logic [15:0] out_token_column,
  output logic        out_last
);
  import stl_pkg::*;

  bundle_t front_bundle, head;
  logic    take, q_full, q_empty, head_pop;
  res_t    res;

  assign in_full = q_full;
  assign take    = in_push && !q_full;

  stl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .func      (in_func),
    .char_byte (in_char_byte),
    .bundle    (front_bundle)
  );

  stl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (take && front_bundle.cnt != 3'd0),
    .wr_data (front_bundle),
    .rd      (head_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  stl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .head_pop   (head_pop),
    .pop        (out_pop),
    .empty      (out_empty),
    .res        (res),
    .last       (out_last)
  );

  assign out_is_text      = res.is_text;
  assign out_text_byte    = res.text_byte;
  assign out_token_kind   = res.kind;
  assign out_token_line   = res.line;
  assign out_token_column = res.column;

endmodule

### tb/token_stream_checker.sv
// Token stream checker for the script text lexer: predicts the results of every
// transferred byte and compares them with the result transfers in order.
// Depends on stl_pkg for modes, token kinds and special characters.
module token_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_char_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_is_text,
  input  logic [7:0]  out_text_byte,
  input  logic [5:0]  out_token_kind,
  input  logic [15:0] out_token_line,
  input  logic [15:0] out_token_column,
  input  logic        out_last,
  output int          fail_count,
  output int          tokens_waiting
);
  import stl_pkg::*;

  typedef struct {
    bit        is_text;
    bit [7:0]  text_byte;
    bit [5:0]  kind;
    bit [15:0] line;
    bit [15:0] column;
    bit        last;
  } token_out_t;

  token_out_t expected_tokens[$];
  token_out_t item_tokens[$];

  // lexer state copy
  logic [3:0] lex_mode;
  bit [7:0]   op_char, quote_char, depth;
  bit [15:0]  line_no, col_no, tok_line, tok_col;
  bit [5:0]   tok_kind;

  function automatic bit [15:0] bump(bit [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit digit_c(bit [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_c(bit [7:0] c);
    return digit_c(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  // single, doubled and '=' suffixed operator kinds; K_NONE where not allowed
  function automatic void op_table(bit [7:0] h, output bit [5:0] k1, output bit [5:0] ks,
                                   output bit [5:0] ke);
    ks = K_NONE;
    ke = K_NONE;
    case (h)
      "=": begin k1 = 17; ke = 18; end
      "?": begin k1 = 19; ke = 20; end
      "!": begin k1 = 23; ke = 24; end
      "~": begin k1 = 25; ke = 26; end
      "*": begin k1 = 27; ke = 28; end
      "@": begin k1 = 29; ks = 30; end
      "<": begin k1 = 31; ks = 32; ke = 33; end
      ">": begin k1 = 34; ks = 35; ke = 36; end
      "|": begin k1 = 37; ks = 38; ke = 39; end
      "&": begin k1 = 40; ks = 41; ke = 42; end
      "+": begin k1 = 43; ks = 44; ke = 45; end
      "%": begin k1 = 49; ks = 50; ke = 51; end
      "^": begin k1 = 52; ks = 53; ke = 54; end
      ":": begin k1 = 55; ks = 56; ke = 57; end
      "-": begin k1 = 46; ks = 47; ke = 48; end
      "/": begin k1 = 21; ke = 22; end
      default: k1 = K_CHRSEQ;
    endcase
  endfunction

  task automatic add_text(bit [7:0] b);
    token_out_t t;
    t = '{1'b1, b, 6'd0, 16'd0, 16'd0, 1'b0};
    if (item_tokens.size() < MAX_RES) item_tokens.push_back(t);
  endtask

  task automatic add_close(bit [5:0] k, bit [15:0] ln, bit [15:0] cl);
    token_out_t t;
    t = '{1'b0, 8'd0, k, ln, cl, 1'b0};
    if (item_tokens.size() < MAX_RES) item_tokens.push_back(t);
  endtask

  task automatic open_tok(bit [5:0] k, bit [15:0] cl, logic [3:0] m);
    tok_kind = k;
    tok_line = line_no;
    tok_col  = cl;
    lex_mode = m;
  endtask

  task automatic begin_token(bit [7:0] c);
    bit [5:0] k1, ks, ke;
    bit [15:0] cl;
    cl = col_no;
    lex_mode = M_IDLE;
    op_table(c, k1, ks, ke);
    case (c)
      CH_CR, CH_LF: begin
        add_close(K_NL, line_no, cl);
        line_no = bump(line_no);
        col_no = 0;
        if (c == CH_CR) lex_mode = M_CR;
      end
      ";": add_close(K_SEMI, line_no, cl);
      ",": add_close(K_COMMA, line_no, cl);
      "#": add_close(K_HASH, line_no, cl);
      "[": add_close(K_LBRK, line_no, cl);
      "]": add_close(K_RBRK, line_no, cl);
      "{": add_close(K_LBRC, line_no, cl);
      "}": add_close(K_RBRC, line_no, cl);
      "(": add_close(K_LPAR, line_no, cl);
      ")": add_close(K_RPAR, line_no, cl);
      CH_DOT: lex_mode = M_DOT1;
      CH_BTICK: lex_mode = M_QUOTE;
      CH_DQUOTE, CH_SQUOTE: begin
        quote_char = c;
        open_tok(c == CH_DQUOTE ? K_STR_DQ : K_STR_SQ, cl, M_STR);
      end
      CH_DOLLAR: begin
        open_tok(K_NUM, cl, M_NUM);
        add_text(CH_ZERO);
        add_text(CH_X);
      end
      default: begin
        if (ke != K_NONE || ks != K_NONE) begin
          op_char = c;
          lex_mode = M_OP;
        end else if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
          // blanks are dropped
        end else if (digit_c(c)) begin
          open_tok(K_NUM, cl, M_NUM);
          add_text(c);
        end else if (word_c(c)) begin
          open_tok(K_ID, cl, M_ID);
          add_text(c);
        end else begin
          add_text(c);
          add_close(K_CHRSEQ, line_no, cl);
        end
      end
    endcase
  endtask

  // one consumed byte; a closed token may hand the byte on to the next mode
  task automatic consume(bit [7:0] c, bit [15:0] prev_col);
    bit [5:0] k1, ks, ke, k;
    bit done;
    done = 0;
    for (int pass = 0; pass < 3 && !done; pass++) begin
      case (lex_mode)
        M_OP: begin
          op_table(op_char, k1, ks, ke);
          k = K_NONE;
          if (c == CH_EQ && ke != K_NONE) k = ke;
          else if (c == op_char && ks != K_NONE) k = ks;
          else if (op_char == CH_MINUS && c == CH_GT) k = K_ARROW;
          if (k != K_NONE) begin
            add_close(k, line_no, col_no);
            lex_mode = M_IDLE;
            done = 1;
          end else if (op_char == CH_MINUS && digit_c(c)) begin
            open_tok(K_NUM, prev_col, M_NUM);
            add_text(CH_MINUS);
            add_text(c);
            done = 1;
          end else if (op_char == CH_SLASH && c == CH_STAR) begin
            open_tok(K_CMT, col_no, M_CMT);
            depth = 1;
            done = 1;
          end else begin
            add_close(k1, line_no, prev_col);
            lex_mode = M_IDLE;
          end
        end
        M_DOT1: begin
          if (c == CH_DOT) begin
            lex_mode = M_DOT2;
            done = 1;
          end else if (digit_c(c)) begin
            open_tok(K_NUM, prev_col, M_NUM);
            add_text(CH_DOT);
            add_text(c);
            done = 1;
          end else begin
            add_close(K_DOT, line_no, prev_col);
            lex_mode = M_IDLE;
          end
        end
        M_DOT2: begin
          lex_mode = M_IDLE;
          if (c == CH_DOT) begin
            add_close(K_DOT3, line_no, col_no);
            done = 1;
          end else begin
            add_close(K_DOT2, line_no, prev_col);
          end
        end
        M_NUM, M_ID: begin
          if (lex_mode == M_NUM ? (word_c(c) || c == CH_DOT) : word_c(c)) begin
            add_text(c);
            done = 1;
          end else begin
            add_close(tok_kind, tok_line, tok_col);
            lex_mode = M_IDLE;
          end
        end
        M_STR: begin
          if (c == quote_char) begin
            add_close(tok_kind, tok_line, tok_col);
            lex_mode = M_IDLE;
          end else begin
            add_text(c);
          end
          done = 1;
        end
        M_QUOTE: begin
          if (c != CH_CR && c != CH_LF) begin
            add_text(c);
            done = 1;
          end else begin
            add_close(K_BTICK, line_no, prev_col);
            lex_mode = M_IDLE;
          end
        end
        M_CMT_SLASH: begin
          lex_mode = M_CMT;
          if (c == CH_STAR) begin
            if (depth != 8'hFF) depth++;
            done = 1;
          end
        end
        M_CMT_STAR: begin
          lex_mode = M_CMT;
          if (c == CH_SLASH) begin
            if (depth > 0) depth--;
            if (depth == 0) begin
              add_close(tok_kind, tok_line, tok_col);
              lex_mode = M_IDLE;
            end
            done = 1;
          end
        end
        M_CMT, M_CMT_CR: begin
          lex_mode = M_CMT;
          if (c == CH_SLASH) lex_mode = M_CMT_SLASH;
          else if (c == CH_STAR) lex_mode = M_CMT_STAR;
          else if (c == CH_CR || c == CH_LF) begin
            line_no = bump(line_no);
            col_no = 0;
            if (c == CH_CR) lex_mode = M_CMT_CR;
          end
          done = 1;
        end
        default: begin
          begin_token(c);
          done = 1;
        end
      endcase
    end
  endtask

  task automatic finish_input();
    bit [5:0] k1, ks, ke;
    case (lex_mode)
      M_OP: begin
        op_table(op_char, k1, ks, ke);
        add_close(k1, line_no, col_no);
      end
      M_DOT1:  add_close(K_DOT, line_no, col_no);
      M_DOT2:  add_close(K_DOT2, line_no, col_no);
      M_QUOTE: add_close(K_BTICK, line_no, col_no);
      M_NUM, M_ID, M_STR, M_CMT, M_CMT_SLASH, M_CMT_STAR, M_CMT_CR:
        add_close(tok_kind, tok_line, tok_col);
      default: ;
    endcase
    add_close(K_EOF, line_no, col_no);
    lex_mode = M_IDLE;
    depth = 0;
  endtask

  task automatic predict_tokens(bit f, bit [7:0] c);
    bit [15:0] prev_col;
    item_tokens.delete();
    if (f) begin
      finish_input();
    end else if ((lex_mode == M_CR || lex_mode == M_CMT_CR) && c == CH_LF) begin
      lex_mode = (lex_mode == M_CR) ? M_IDLE : M_CMT;
    end else begin
      prev_col = col_no;
      col_no = bump(col_no);
      consume(c, prev_col);
    end
    if (item_tokens.size() > 0) item_tokens[item_tokens.size()-1].last = 1'b1;
    foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
  endtask

  initial fail_count = 0;

  // compare result transfers, then predict from input transfers
  always @(posedge clk) begin
    token_out_t e;
    if (!rst_n) begin
      expected_tokens.delete();
      lex_mode = M_IDLE;
      op_char = 0; quote_char = 0; depth = 0;
      line_no = 0; col_no = 0;
      tok_kind = 0; tok_line = 0; tok_col = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          e = expected_tokens.pop_front();
          if (out_is_text !== e.is_text) begin
            $error("is_text: expected %0d, got %0d", e.is_text, out_is_text);
            fail_count++;
          end
          if (out_text_byte !== e.text_byte) begin
            $error("text_byte: expected %0h, got %0h", e.text_byte, out_text_byte);
            fail_count++;
          end
          if (out_token_kind !== e.kind) begin
            $error("token_kind: expected %0d, got %0d", e.kind, out_token_kind);
            fail_count++;
          end
          if (out_token_line !== e.line) begin
            $error("token_line: expected %0d, got %0d", e.line, out_token_line);
            fail_count++;
          end
          if (out_token_column !== e.column) begin
            $error("token_column: expected %0d, got %0d", e.column, out_token_column);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) predict_tokens(in_func, in_char_byte);
    end
    tokens_waiting = expected_tokens.size();
  end
endmodule

### tb/tb.sv
// Testbench top for script_text_lexer_unit: clock, reset, byte stimulus,
// result pop pressure and verdict. Uses token_stream_checker and stl_pkg.
module tb;
  import stl_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_func = 0;
  logic [7:0]  in_char_byte = 0;
  logic        out_pop = 0;
  logic        in_full, out_empty, out_is_text, out_last;
  logic [7:0]  out_text_byte;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_line, out_token_column;
  int          fail_count, tokens_waiting;
  int          bytes_sent = 0;
  bit          steady = 0;
  bit          hold_pop = 0;

  always #10 clk = ~clk;

  script_text_lexer_unit u_top (.*);

  token_stream_checker u_chk (.*);

  // result side: random pops, none while held off
  always @(posedge clk)
    out_pop <= rst_n && !hold_pop && (steady || $urandom_range(0, 99) >= 27);

  // long pop hold-off so the bundle queue fills and stalls the input
  initial begin
    wait (bytes_sent >= 40);
    @(posedge clk);
    hold_pop = 1;
    repeat (80) @(posedge clk);
    hold_pop = 0;
  end

  // full only changes at a rising edge, so it is sampled mid-cycle
  task automatic send_item(bit f, bit [7:0] c);
    if (!steady && $urandom_range(0, 99) < 27) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_func      <= f;
    in_char_byte <= c;
    do @(negedge clk); while (in_full);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(1'b0, s[i]);
  endtask

  task automatic send_word(bit digits_ok, int n);
    string pool;
    pool = "abcxyzABQZ_019";
    for (int i = 0; i < n; i++)
      send_item(1'b0, pool[$urandom_range(0, digits_ok ? 13 : 10)]);
  endtask

  // one random token, mostly well formed
  task automatic send_token();
    string ops, puncts;
    bit [7:0] q, b;
    int nest;
    ops = "=?!~*@<>|&+%^:-/";
    puncts = ";,#[]{}()";
    case ($urandom_range(0, 13))
      0: send_word(0, $urandom_range(1, 5));
      1: begin
        send_item(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
        send_word(1, $urandom_range(0, 3));
        if ($urandom_range(0, 1)) send_text(".5");
      end
      2: begin send_item(1'b0, CH_DOLLAR); send_word(1, $urandom_range(0, 3)); end
      3: case ($urandom_range(0, 3))
        0: send_text(".9");
        1: send_text("..");
        2: send_text("...");
        default: send_text(".");
      endcase
      4: send_text($urandom_range(0, 1) ? "-7" : "->");
      5: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send_item(1'b0, q);
        repeat ($urandom_range(0, 5)) begin
          do b = 8'($urandom_range(0, 255)); while (b == q);
          send_item(1'b0, b);
        end
        send_item(1'b0, q);
      end
      6: begin
        send_item(1'b0, CH_BTICK);
        repeat ($urandom_range(0, 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
          send_item(1'b0, b);
        end
        send_text($urandom_range(0, 1) ? "\n" : "\r\n");
      end
      7: begin
        send_text("/*");
        nest = 1;
        while (nest > 0) begin
          case ($urandom_range(0, 5))
            0: if (nest < 3) begin send_text("/*"); nest++; end
            1: begin send_text("*/"); nest--; end
            2: send_text("\r\n");
            default: begin
              do b = 8'($urandom_range(0, 255)); while (b == CH_SLASH || b == CH_STAR);
              send_item(1'b0, b);
            end
          endcase
        end
      end
      8: begin
        b = ops[$urandom_range(0, 15)];
        send_item(1'b0, b);
        case ($urandom_range(0, 2))
          0: send_item(1'b0, b);
          1: send_item(1'b0, CH_EQ);
          default: ;
        endcase
      end
      9: send_item(1'b0, puncts[$urandom_range(0, 8)]);
      10: send_item(1'b0, $urandom_range(0, 1) ? " " : 8'h09);
      11: case ($urandom_range(0, 2))
        0: send_item(1'b0, CH_CR);
        1: send_item(1'b0, CH_LF);
        default: send_text("\r\n");
      endcase
      12: send_item(1'b0, 8'($urandom_range(0, 255)));
      default: if ($urandom_range(0, 3) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
               else send_item(1'b0, 8'h0B);
    endcase
    if ($urandom_range(0, 1)) send_item(1'b0, 8'h0C);
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: words, numbers, dots, arrow, backtick, CRLF, strings, nesting
    send_text("a_9$f.7-3->...`x\r\n'q'/*/**/*/");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h80);
    send_item(1'b1, 8'hFF);
    send_text("\"a\nb");
    send_item(1'b1, 8'h00);

    // random tokens, with a stretch of no idling on either side
    while (bytes_sent < 215) begin
      steady = (bytes_sent >= 120 && bytes_sent < 170);
      send_token();
    end
    steady = 0;
    send_item(1'b1, 8'h00);

    in_push <= 1'b0;
    @(posedge clk);
    while (tokens_waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && tokens_waiting == 0) begin
      $display("[script_text_lexer_unit] OK");
    end else begin
      $display("[script_text_lexer_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[script_text_lexer_unit] ERROR");
    $finish;
  end
endmodule

### script_text_lexer_unit.f
design/stl_pkg.sv
design/stl_front.sv
design/stl_queue.sv
design/stl_back.sv
design/script_text_lexer_unit.sv
tb/token_stream_checker.sv
tb/tb.sv
